// ----- design/mep_pkg.sv -----
`default_nettype none

package mep_pkg;

    localparam int FRAC_BITS = 28;
    localparam int Q_W       = FRAC_BITS + 4;

    localparam int IDX_W     = 24;
    localparam int DIM_W     = 13;
    localparam int PIX_W     = 25;
    localparam int CNT_W     = 12;
    localparam int GRAY_W    = 8;
    localparam int WORD_W    = 32;

    localparam int NUM_W     = 25;
    localparam int DEN_W     = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam int IN_TDATA_W  = ((IDX_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = IDX_W + CNT_W + WORD_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = PIX_W;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXELS = 2'd2;

    localparam logic [GRAY_W-1:0] ALPHA = 8'hFF;

    typedef logic signed [Q_W-1:0] q_t;

    localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [PIX_W-1:0] pixels;
    } mep_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        q_t               cr;
        q_t               ci;
    } mep_item_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [NUM_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } mep_ratio_req_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SPLIT,
        F_MAP,
        F_WAIT
    } mep_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_UPD
    } mep_back_state_t;

endpackage

`default_nettype wire

// ----- design/mep_ratio.sv -----
`default_nettype none

module mep_ratio (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire mep_pkg::mep_ratio_req_t req,
    output logic                         busy,
    output mep_pkg::q_t                  value
);
    import mep_pkg::*;

    localparam int D_W    = DEN_W + 3;
    localparam int STEP_W = $clog2(Q_W);

    logic              busy_reg, busy_next;
    logic              sat_reg, sat_next;
    logic              neg_reg, neg_next;
    logic [D_W-1:0]    d_reg, d_next;
    logic [D_W-1:0]    rem_reg, rem_next;
    logic [Q_W-1:0]    quo_reg, quo_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    logic [D_W-1:0] d_full;
    logic           over;
    logic [D_W:0]   t;
    logic [D_W:0]   diff;
    logic           ge;
    logic [Q_W:0]   rnd;
    logic [Q_W-1:0] mag_r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        sat_reg <= sat_next;
        neg_reg <= neg_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        d_full = {req.den, 3'b000};
        over   = req.mag >= NUM_W'(d_full);
        t      = {rem_reg, 1'b0};
        diff   = t - {1'b0, d_reg};
        ge     = t >= {1'b0, d_reg};

        busy_next = busy_reg;
        sat_next  = sat_reg;
        neg_next  = neg_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;

        if (req.start) begin
            neg_next  = req.neg;
            d_next    = d_full;
            sat_next  = over;
            busy_next = !over;
            rem_next  = req.mag[D_W-1:0];
            quo_next  = '0;
            cnt_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? diff[D_W-1:0] : t[D_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(Q_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // round half away from zero on the magnitude
    always_comb begin
        rnd   = {1'b0, quo_reg} + (Q_W + 1)'(1);
        mag_r = rnd[Q_W:1];
        if (sat_reg) begin
            value = neg_reg ? Q_MIN : Q_MAX;
        end else if (neg_reg) begin
            value = q_t'(Q_W'(0) - mag_r);
        end else if (mag_r[Q_W-1]) begin
            value = Q_MAX;
        end else begin
            value = q_t'(mag_r);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

// ----- design/mep_fifo.sv -----
`default_nettype none

module mep_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire mep_pkg::mep_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    valid,
    output mep_pkg::mep_item_t      head
);
    import mep_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    mep_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full    = count_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/mep_front.sv -----
`default_nettype none

module mep_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire mep_pkg::mep_cfg_t              cfg,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mep_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                                push,
    output mep_pkg::mep_item_t                  push_item,
    input  wire logic                           full
);
    import mep_pkg::*;

    localparam int STEP_W = $clog2(IDX_W);
    localparam int CR_W   = DIM_W + 4;

    mep_front_state_t  state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DIM_W-1:0]  w_reg, w_next;
    logic [DIM_W-1:0]  h_reg, h_next;
    logic [IDX_W-1:0]  quo_reg, quo_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    logic [DIM_W:0]   t;
    logic [DIM_W:0]   diff;
    logic             ge;
    logic [CR_W-1:0]  cr_a, cr_b;
    logic [NUM_W-1:0] ci_a, ci_b;
    logic             in_range;

    mep_ratio_req_t cr_req, ci_req;
    logic           cr_busy, ci_busy;
    q_t             cr_val, ci_val;

    mep_ratio u_cr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cr_req),
        .busy    (cr_busy),
        .value   (cr_val)
    );

    mep_ratio u_ci (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ci_req),
        .busy    (ci_busy),
        .value   (ci_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        idx_reg <= idx_next;
        w_reg   <= w_next;
        h_reg   <= h_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    // real axis: (14*col - 10*W) / (7*W); imaginary axis: (2*row - H) / H
    always_comb begin
        cr_a = CR_W'(rem_reg) * CR_W'(14);
        cr_b = CR_W'(w_reg) * CR_W'(10);
        ci_a = {quo_reg, 1'b0};
        ci_b = NUM_W'(h_reg);

        cr_req.start = 1'b0;
        cr_req.neg   = cr_b > cr_a;
        cr_req.mag   = cr_req.neg ? NUM_W'(cr_b - cr_a) : NUM_W'(cr_a - cr_b);
        cr_req.den   = DEN_W'(w_reg) * DEN_W'(7);

        ci_req.start = 1'b0;
        ci_req.neg   = ci_b > ci_a;
        ci_req.mag   = ci_req.neg ? ci_b - ci_a : ci_a - ci_b;
        ci_req.den   = DEN_W'(h_reg);

        t        = {rem_reg, quo_reg[IDX_W-1]};
        diff     = t - {1'b0, w_reg};
        ge       = t >= {1'b0, w_reg};
        in_range = {1'b0, s_tdata[IDX_W-1:0]} < cfg.pixels;

        state_next = state_reg;
        idx_next   = idx_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        push       = 1'b0;
        push_item  = '{idx: idx_reg, cr: cr_val, ci: ci_val};

        case (state_reg)
            F_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && in_range) begin
                    idx_next   = s_tdata[IDX_W-1:0];
                    quo_next   = s_tdata[IDX_W-1:0];
                    w_next     = (cfg.width == '0) ? DIM_W'(1) : cfg.width;
                    h_next     = (cfg.height == '0) ? DIM_W'(1) : cfg.height;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = F_SPLIT;
                end
            end
            F_SPLIT: begin
                rem_next = ge ? diff[DIM_W-1:0] : t[DIM_W-1:0];
                quo_next = {quo_reg[IDX_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(IDX_W - 1)) begin
                    state_next = F_MAP;
                end
            end
            F_MAP: begin
                cr_req.start = 1'b1;
                ci_req.start = 1'b1;
                state_next   = F_WAIT;
            end
            F_WAIT: begin
                if (!cr_busy && !ci_busy && !full) begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/mep_back.sv -----
`default_nettype none

module mep_back #(
    parameter int MAX_ITER = 100
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_valid,
    input  wire mep_pkg::mep_item_t              q_head,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [mep_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import mep_pkg::*;

    localparam int P2_W  = 2 * Q_W;
    localparam int P_W   = Q_W + 4;
    localparam int S_W   = Q_W + 5;
    localparam int TWO_M = 2 * MAX_ITER;
    localparam int G_Q   = 510 / TWO_M;
    localparam int G_R   = 510 % TWO_M;
    localparam int RW    = $clog2(4 * MAX_ITER);
    localparam int PAD_W = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [P_W:0] ESC_LIM = (P_W + 1)'(4) << FRAC_BITS;

    mep_back_state_t         state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    q_t                      cr_reg, cr_next;
    q_t                      ci_reg, ci_next;
    q_t                      zr_reg, zr_next;
    q_t                      zi_reg, zi_next;
    logic signed [P2_W-1:0]  prr_reg, prr_next;
    logic signed [P2_W-1:0]  pii_reg, pii_next;
    logic signed [P2_W-1:0]  pri_reg, pri_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic [GRAY_W-1:0]       g_reg, g_next;
    logic [RW-1:0]           r_reg, r_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic signed [P_W-1:0] zr2, zi2, zri;
    logic signed [S_W-1:0] nr_w, ni_w;
    logic [P_W:0]          lsq;
    logic                  esc, lim, fin, out_free;
    logic [RW-1:0]         r_sum;
    logic [CNT_W-1:0]      cnt_out;
    logic [GRAY_W-1:0]     g_out;

    // product scaled back to Q4 format, truncated toward zero
    function automatic logic signed [P_W-1:0] trunc_prod(input logic signed [P2_W-1:0] p);
        logic signed [P2_W-1:0] sh;
        logic                   corr;
        sh   = p >>> FRAC_BITS;
        corr = p[P2_W-1] & (|p[FRAC_BITS-1:0]);
        return sh[P_W-1:0] + {{(P_W-1){1'b0}}, corr};
    endfunction

    function automatic q_t sat_q(input logic signed [S_W-1:0] v);
        if (v > S_W'(Q_MAX)) begin
            return Q_MAX;
        end else if (v < S_W'(Q_MIN)) begin
            return Q_MIN;
        end else begin
            return q_t'(v[Q_W-1:0]);
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg     <= idx_next;
        cr_reg      <= cr_next;
        ci_reg      <= ci_next;
        zr_reg      <= zr_next;
        zi_reg      <= zi_next;
        prr_reg     <= prr_next;
        pii_reg     <= pii_next;
        pri_reg     <= pri_next;
        k_reg       <= k_next;
        g_reg       <= g_next;
        r_reg       <= r_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        zr2  = trunc_prod(prr_reg);
        zi2  = trunc_prod(pii_reg);
        zri  = trunc_prod(pri_reg);
        nr_w = S_W'(zr2) - S_W'(zi2) + S_W'(cr_reg);
        ni_w = (S_W'(zri) <<< 1) + S_W'(ci_reg);
        lsq  = {1'b0, zr2} + {1'b0, zi2};

        esc      = (k_reg != '0) && (lsq >= ESC_LIM);
        lim      = k_reg == CNT_W'(MAX_ITER);
        fin      = esc || lim;
        out_free = !m_tvalid_reg || m_tready;
        cnt_out  = lim ? '0 : k_reg;
        g_out    = lim ? '0 : g_reg;
        r_sum    = r_reg + RW'(G_R);

        state_next    = state_reg;
        idx_next      = idx_reg;
        cr_next       = cr_reg;
        ci_next       = ci_reg;
        zr_next       = zr_reg;
        zi_next       = zi_reg;
        prr_next      = prr_reg;
        pii_next      = pii_reg;
        pri_next      = pri_reg;
        k_next        = k_reg;
        g_next        = g_reg;
        r_next        = r_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        q_pop         = 1'b0;

        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    idx_next   = q_head.idx;
                    cr_next    = q_head.cr;
                    ci_next    = q_head.ci;
                    zr_next    = '0;
                    zi_next    = '0;
                    k_next     = '0;
                    g_next     = '0;
                    r_next     = RW'(MAX_ITER);
                    state_next = B_MUL;
                end
            end
            B_MUL: begin
                prr_next   = zr_reg * zr_reg;
                pii_next   = zi_reg * zi_reg;
                pri_next   = zr_reg * zi_reg;
                state_next = B_UPD;
            end
            B_UPD: begin
                if (fin) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = {{PAD_W{1'b0}}, ALPHA, g_out, g_out, g_out,
                                         cnt_out, idx_reg};
                        state_next    = B_IDLE;
                    end
                end else begin
                    zr_next = sat_q(nr_w);
                    zi_next = sat_q(ni_w);
                    k_next  = k_reg + 1'b1;
                    // gray = (510*k + MAX) / (2*MAX), kept as quotient and remainder
                    if (r_sum >= RW'(TWO_M)) begin
                        r_next = r_sum - RW'(TWO_M);
                        g_next = g_reg + GRAY_W'(G_Q) + 1'b1;
                    end else begin
                        r_next = r_sum;
                        g_next = g_reg + GRAY_W'(G_Q);
                    end
                    state_next = B_MUL;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- design/mandelbrot_escape_pixel_unit.sv -----
`default_nettype none

// Mandelbrot escape-time pixel unit. Each input transaction carries a linear
// pixel index; indices at or above frame_pixels are consumed without a result.
// The front end splits the index into row and column with a 24-step
// shift-subtract divider, then maps both to a Q4.28 point c with two 32-step
// dividers working side by side. A two-entry queue feeds the back end, which
// iterates z = z^2 + c, each iteration forming three 32x32 products and then
// doing the update and escape test. Each half works on one pixel at a time;
// the back end sets sustained throughput for deep pixels, the front end for
// pixels that escape early. A finished result sits in the output register
// while the next pixel is already running. Configuration is a plain
// write port: 0 frame_width, 1 frame_height, 2 frame_pixels; a zero
// width or height acts as one.
module mandelbrot_escape_pixel_unit #(
    parameter int MAX_ITER = 100
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mep_pkg::IN_TDATA_W-1:0]  s_tdata,   // [23:0] pixel_index
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [23:0] out_index, [35:24] iteration_count, [67:36] pixel_word
    output logic [mep_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mep_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [mep_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
    import mep_pkg::*;

    localparam int CNT_LO  = IDX_W;
    localparam int WORD_LO = IDX_W + CNT_W;

    mep_cfg_t  cfg_reg, cfg_next;
    logic      q_push, q_full, q_pop, q_valid;
    mep_item_t q_in, q_head;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WIDTH:  cfg_next.width  = cfg_wdata[DIM_W-1:0];
                REG_HEIGHT: cfg_next.height = cfg_wdata[DIM_W-1:0];
                REG_PIXELS: cfg_next.pixels = cfg_wdata[PIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= DIM_W'(1920);
            cfg_reg.height <= DIM_W'(1080);
            cfg_reg.pixels <= PIX_W'(2073600);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mep_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full)
    );

    mep_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    mep_back #(
        .MAX_ITER (MAX_ITER)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_count_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[WORD_LO-1:CNT_LO] < CNT_W'(MAX_ITER)))
        else $error("iteration count at or above the limit");

    a_gray_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[WORD_LO-1:CNT_LO] == '0))
            |-> (m_tdata[WORD_LO+3*GRAY_W-1:WORD_LO] == '0))
        else $error("nonzero gray for a pixel inside the set");

    a_gray_word : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[WORD_LO+WORD_W-1:WORD_LO+3*GRAY_W] == ALPHA)
            && (m_tdata[WORD_LO+GRAY_W-1:WORD_LO]
                == m_tdata[WORD_LO+2*GRAY_W-1:WORD_LO+GRAY_W])
            && (m_tdata[WORD_LO+GRAY_W-1:WORD_LO]
                == m_tdata[WORD_LO+3*GRAY_W-1:WORD_LO+2*GRAY_W])))
        else $error("malformed pixel word");

    a_index_in_frame : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[IDX_W-1:0]} < cfg_reg.pixels))
        else $error("result for an index outside the frame");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_mandelbrot_escape_pixel_unit.sv -----
`timescale 1ns / 100ps

module tb_mandelbrot_escape_pixel_unit;

    import mep_pkg::*;

    localparam int MAX_ITER     = 100;
    localparam int HALF_PERIOD  = 6;
    localparam int DRAIN_CYCLES = 2 * MAX_ITER + 200;
    localparam int STALL_LONG   = 3000;
    localparam int WATCHDOG_MAX = 20000;
    localparam longint Q_LIM    = longint'(1) << (FRAC_BITS + 3);
    localparam longint IDX_SPAN = longint'(1) << IDX_W;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct {
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] word;
    } pixel_result_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr  = '0;
    logic [CFG_DAT_W-1:0]   cfg_wdata = '0;

    // frame registers as the block should hold them
    logic [DIM_W-1:0] frame_w = 13'd1920;
    logic [DIM_W-1:0] frame_h = 13'd1080;
    logic [PIX_W-1:0] frame_p = 25'd2073600;

    logic [IDX_W-1:0] pending_px[$];
    pixel_result_t    pending_results[$];
    pixel_result_t    predicted;
    pixel_result_t    seen;
    pixel_result_t    oldest;

    logic in_fire = 1'b0;
    int   burst_left;
    int   gap_left;
    int   sink_left;
    logic sink_ready;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_left;
    int   mismatches    = 0;
    int   idle_cycles   = 0;

    logic [IDX_W-1:0] opening_px[12] = '{
        24'd0, 24'd1, 24'd1919, 24'd1920, 24'd1038171, 24'd1036800,
        24'd518880, 24'd699050, 24'd2073599, 24'd2073600, 24'h555555, 24'hFFFFFF
    };

    mandelbrot_escape_pixel_unit #(
        .MAX_ITER(MAX_ITER)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    function automatic longint q4_clamp(input longint v);
        if (v >= Q_LIM) return Q_LIM - 1;
        if (v < -Q_LIM) return -Q_LIM;
        return v;
    endfunction

    // num / den in Q4 fixed point, nearest with halves away from zero
    function automatic longint q4_ratio(input longint num, input longint den);
        logic   neg;
        longint m;
        longint q;
        longint r;
        longint mag;
        neg = num < 0;
        m   = neg ? -num : num;
        q   = (m << FRAC_BITS) / den;
        r   = (m << FRAC_BITS) % den;
        mag = q + ((2 * r >= den) ? 1 : 0);
        return q4_clamp(neg ? -mag : mag);
    endfunction

    // product truncated toward zero
    function automatic longint q_mul(input longint a, input longint b);
        logic   neg;
        longint ua;
        longint ub;
        longint r;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        r   = (ua * ub) >> FRAC_BITS;
        return neg ? -r : r;
    endfunction

    function automatic bit escape_pixel(input logic [IDX_W-1:0] px,
                                        output pixel_result_t res);
        longint w;
        longint h;
        longint row;
        longint col;
        longint cr;
        longint ci;
        longint zr;
        longint zi;
        longint zr2;
        longint zi2;
        longint zri;
        longint nr;
        longint ni;
        int     k;
        logic [GRAY_W-1:0] g;
        if (longint'(px) >= longint'(frame_p)) return 1'b0;
        w   = (frame_w == 0) ? 1 : longint'(frame_w);
        h   = (frame_h == 0) ? 1 : longint'(frame_h);
        row = longint'(px) / w;
        col = longint'(px) % w;
        cr  = q4_ratio(14 * col - 10 * w, 7 * w);
        ci  = q4_ratio(2 * row - h, h);
        zr  = 0;
        zi  = 0;
        zr2 = 0;
        zi2 = 0;
        k   = 0;
        do begin
            zri = q_mul(zr, zi);
            nr  = q4_clamp(zr2 - zi2 + cr);
            ni  = q4_clamp(2 * zri + ci);
            zr  = nr;
            zi  = ni;
            zr2 = q_mul(zr, zr);
            zi2 = q_mul(zi, zi);
            k++;
        end while (zr2 + zi2 < (longint'(4) << FRAC_BITS) && k < MAX_ITER);
        if (k == MAX_ITER) k = 0;
        g = GRAY_W'((k * 510 + MAX_ITER) / (2 * MAX_ITER));
        res.index = px;
        res.count = CNT_W'(k);
        res.word  = {ALPHA, g, g, g};
        return 1'b1;
    endfunction

    // input side: prediction on accept; output side: check against oldest expectation
    always @(posedge aclk) begin
        in_fire <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready && escape_pixel(s_tdata[IDX_W-1:0], predicted))
                pending_results.push_back(predicted);
            if (m_tvalid && m_tready) begin
                seen.index = m_tdata[IDX_W-1:0];
                seen.count = m_tdata[IDX_W +: CNT_W];
                seen.word  = m_tdata[IDX_W + CNT_W +: WORD_W];
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: idx=%0d cnt=%0d word=%h",
                                 seen.index, seen.count, seen.word);
                end else begin
                    oldest = pending_results.pop_front();
                    if (seen.index != oldest.index || seen.count != oldest.count ||
                        seen.word != oldest.word) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp idx=%0d cnt=%0d word=%h, got idx=%0d cnt=%0d word=%h",
                                     oldest.index, oldest.count, oldest.word,
                                     seen.index, seen.count, seen.word);
                    end
                end
            end
        end
    end

    // sender: bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else if (s_tvalid && !in_fire) begin
            // transaction still offered
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (pending_px.size() != 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= pending_px.pop_front();
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 24);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: gap_left = 0;
                    5, 6, 7:       gap_left = $urandom_range(1, 12);
                    default:       gap_left = $urandom_range(20, 260);
                endcase
            end else begin
                burst_left--;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver: alternating ready and stall runs, plus an occasional long holdoff
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_left = 0;
            hold_left = 0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = STALL_LONG;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (sink_left == 0) begin
                sink_ready = $urandom_range(0, 2) != 0;
                sink_left  = sink_ready ? $urandom_range(1, 300) : $urandom_range(1, 40);
            end
            sink_left--;
            m_tready <= sink_ready;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("** mandelbrot_escape_pixel_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic quiesce();
        while (pending_px.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] addr,
                             input logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_WIDTH:  frame_w = data[DIM_W-1:0];
            REG_HEIGHT: frame_h = data[DIM_W-1:0];
            REG_PIXELS: frame_p = data;
            default:    ;
        endcase
    endtask

    task automatic set_frame(input logic [CFG_DAT_W-1:0] w_data,
                             input logic [CFG_DAT_W-1:0] h_data,
                             input logic [CFG_DAT_W-1:0] p_data);
        quiesce();
        cfg_write(REG_WIDTH, w_data);
        cfg_write(REG_HEIGHT, h_data);
        cfg_write(REG_PIXELS, p_data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly in-frame indices, with edges, out-of-frame and full-range ones mixed in
    task automatic queue_pixels(input int n);
        longint           lim;
        logic [IDX_W-1:0] px;
        int               pick;
        lim = (longint'(frame_p) > IDX_SPAN) ? IDX_SPAN : longint'(frame_p);
        repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick == 0 || lim == 0)
                px = IDX_W'($urandom());
            else if (pick == 1)
                px = IDX_W'(lim);
            else if (pick == 2)
                px = IDX_W'(lim - 1);
            else
                px = IDX_W'($urandom_range(0, int'(lim - 1)));
            pending_px.push_back(px);
        end
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // reset frame: corners, last pixel, first out-of-frame, set interior
        foreach (opening_px[i]) pending_px.push_back(opening_px[i]);
        queue_pixels(80);

        set_frame(25'd16, 25'd12, 25'd250);
        queue_pixels(80);

        set_frame(25'd1, 25'd1, 25'h1000000);
        queue_pixels(60);

        // zero width and height act as one; unmapped index must be ignored
        set_frame(25'd0, 25'd0, 25'h1FFFFFF);
        cfg_write(REG_NONE, 25'h0ABCDEF);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        queue_pixels(40);

        set_frame(25'd4096, 25'd4096, 25'h1000000);
        queue_pixels(120);

        // bits above the 13-bit width field are dropped
        set_frame({12'hA5A, 13'h1FFF}, 25'd8191, 25'd100000);
        queue_pixels(60);

        set_frame(25'd7, 25'd5, 25'd1);
        queue_pixels(10);

        set_frame(25'd7, 25'd5, 25'd0);
        queue_pixels(6);

        // sink holds off while the source keeps pushing
        set_frame(25'd64, 25'd48, 25'd3072);
        queue_pixels(150);
        hold_requests++;

        set_frame(25'd3, 25'd2, 25'd10);
        queue_pixels(50);

        quiesce();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** mandelbrot_escape_pixel_unit: PASSED **");
        else
            $display("** mandelbrot_escape_pixel_unit: FAILED **");
        $finish;
    end

endmodule
